// File: hw/rtl/owm_pkg.sv
// Shared types and constants of the one-wire bus master.
package owm_pkg;

    localparam int COUNT_WIDTH   = 10;
    localparam int REG_WIDTH     = 10;
    localparam int NUM_REGS      = 7;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int REQ_WIDTH     = 2;
    localparam int BYTE_WIDTH    = 8;
    localparam int BIT_IDX_WIDTH = 3;

    localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

    typedef logic [REG_WIDTH-1:0]   t_reg;
    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [BYTE_WIDTH-1:0]  t_byte;

    typedef enum logic [REQ_WIDTH-1:0] {
        REQ_TICK  = 2'd0,
        REQ_RESET = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_RESET_LOW     = 3'd0,
        CFG_PRESENCE_WAIT = 3'd1,
        CFG_RESET_RECOVER = 3'd2,
        CFG_SHORT_LOW     = 3'd3,
        CFG_LONG_LOW      = 3'd4,
        CFG_READ_SAMPLE   = 3'd5,
        CFG_READ_TAIL     = 3'd6
    } t_cfg_idx;

    localparam t_reg INIT_RESET_LOW     = 10'd480;
    localparam t_reg INIT_PRESENCE_WAIT = 10'd80;
    localparam t_reg INIT_RESET_RECOVER = 10'd400;
    localparam t_reg INIT_SHORT_LOW     = 10'd1;
    localparam t_reg INIT_LONG_LOW      = 10'd60;
    localparam t_reg INIT_READ_SAMPLE   = 10'd10;
    localparam t_reg INIT_READ_TAIL     = 10'd50;

endpackage

// File: hw/rtl/owm_cmd_if.sv
// Command channel of the one-wire bus master.
interface owm_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [owm_pkg::REQ_WIDTH-1:0]       req_type;
    logic [owm_pkg::BYTE_WIDTH-1:0]      tx_byte;
    logic                                line_level;

    modport source (output valid, output req_type, output tx_byte, output line_level,
                    input ready);
    modport sink   (input valid, input req_type, input tx_byte, input line_level,
                    output ready);
endinterface

// File: hw/rtl/owm_res_if.sv
// Result channel of the one-wire bus master.
interface owm_res_if;
    logic                                valid;
    logic                                ready;
    logic                                drive_low;
    logic                                busy_res;
    logic                                done_res;
    logic                                presence;
    logic [owm_pkg::BYTE_WIDTH-1:0]      rx_byte;
    logic                                rejected;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence, output rx_byte, output rejected, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input presence, input rx_byte, input rejected, output ready);
endinterface

// File: hw/rtl/one_wire_master_controller.sv
// One-wire bus master: command/tick sequencer with timing registers.
//
// Usage: i_cmd carries one word per item: a tick (one microsecond, with the
// sampled line level), a bus reset, a write-byte or a read-byte command.
// o_res returns exactly one word per item: drive_low, busy_res, done_res,
// presence, rx_byte and rejected. Commands while busy are rejected.
// Timing registers are written through i_cfg_we / i_cfg_idx / i_cfg_data
// by the user only while the block is idle, which the block does not enforce;
// writes to index 7 are dropped. An accepted item goes from the input
// register through the single-pass step logic into the result register, a
// two-stage pipe taking one item per cycle while o_res does not stall.
// One tick may chain through several zero-length phases; a zero-length
// byte is finished in closed form within the same cycle.
// Reset (i_rst_n low, synchronous): phase idle, counters and shifters clear,
// timing registers return to their defaults, both pipe stages empty.
// Stall: while o_res.ready is low the result word holds; one more item is
// taken into the input register, then i_cmd.ready drops.
module one_wire_master_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [owm_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_idx,
    input  logic [owm_pkg::REG_WIDTH-1:0]       i_cfg_data,
    owm_cmd_if.sink                             i_cmd,
    owm_res_if.source                           o_res
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_REC,
        PH_WR_LOW, PH_WR_HIGH, PH_RD_LOW, PH_RD_WAIT, PH_RD_TAIL
    } t_phase;

    typedef struct packed {
        t_phase                              phase;
        owm_pkg::t_count                     time_left;
        logic [owm_pkg::BIT_IDX_WIDTH-1:0]   bit_index;
        owm_pkg::t_byte                      tx_shift;
        owm_pkg::t_byte                      rx_shift;
        logic                                presence;
    } t_state;

    typedef struct packed {
        t_state st;
        logic   done;
    } t_step;

    typedef struct packed {
        owm_pkg::t_count rst_low;
        owm_pkg::t_count pres_wait;
        owm_pkg::t_count rst_rec;
        owm_pkg::t_count short_low;
        owm_pkg::t_count long_low;
        owm_pkg::t_count rd_sample;
        owm_pkg::t_count rd_tail;
    } t_counts;

    function automatic owm_pkg::t_count load_count(owm_pkg::t_reg v);
        logic [31:0] ext;
        ext = 32'(v);
        if (ext > owm_pkg::CNT_MAX) begin
            return owm_pkg::t_count'(owm_pkg::CNT_MAX);
        end
        return owm_pkg::t_count'(ext);
    endfunction

    function automatic t_step step(t_step a, logic level, t_counts c);
        t_step r;
        r = a;
        if (a.st.phase != PH_IDLE && a.st.time_left == '0) begin
            unique case (a.st.phase)
                PH_RST_LOW: begin
                    r.st.phase     = PH_RST_WAIT;
                    r.st.time_left = c.pres_wait;
                end
                PH_RST_WAIT: begin
                    r.st.presence  = !level;
                    r.st.phase     = PH_RST_REC;
                    r.st.time_left = c.rst_rec;
                end
                PH_RST_REC: begin
                    r.st.phase     = PH_IDLE;
                    r.st.time_left = '0;
                    r.done         = 1'b1;
                end
                PH_WR_LOW: begin
                    r.st.phase     = PH_WR_HIGH;
                    r.st.time_left = a.st.tx_shift[0] ? c.long_low : c.short_low;
                end
                PH_WR_HIGH: begin
                    r.st.tx_shift = a.st.tx_shift >> 1;
                    if (a.st.bit_index == '1) begin
                        r.st.bit_index = '0;
                        r.st.phase     = PH_IDLE;
                        r.st.time_left = '0;
                        r.done         = 1'b1;
                    end else begin
                        r.st.bit_index = a.st.bit_index + 1'b1;
                        r.st.phase     = PH_WR_LOW;
                        r.st.time_left = a.st.tx_shift[1] ? c.short_low : c.long_low;
                    end
                end
                PH_RD_LOW: begin
                    r.st.phase     = PH_RD_WAIT;
                    r.st.time_left = c.rd_sample;
                end
                PH_RD_WAIT: begin
                    if (level) begin
                        r.st.rx_shift[a.st.bit_index] = 1'b1;
                    end
                    r.st.phase     = PH_RD_TAIL;
                    r.st.time_left = c.rd_tail;
                end
                PH_RD_TAIL: begin
                    if (a.st.bit_index == '1) begin
                        r.st.bit_index = '0;
                        r.st.phase     = PH_IDLE;
                        r.st.time_left = '0;
                        r.done         = 1'b1;
                    end else begin
                        r.st.bit_index = a.st.bit_index + 1'b1;
                        r.st.phase     = PH_RD_LOW;
                        r.st.time_left = c.short_low;
                    end
                end
                default: begin
                    r.st.phase     = PH_IDLE;
                    r.st.time_left = '0;
                end
            endcase
        end
        return r;
    endfunction

    owm_pkg::t_reg                   r_cfg [owm_pkg::NUM_REGS];
    t_state                          r_state;
    logic                            r_in_valid;
    logic [owm_pkg::REQ_WIDTH-1:0]   r_in_req;
    owm_pkg::t_byte                  r_in_tx;
    logic                            r_in_level;
    logic                            r_out_valid;
    logic                            r_out_drive;
    logic                            r_out_busy;
    logic                            r_out_done;
    logic                            r_out_presence;
    owm_pkg::t_byte                  r_out_rx;
    logic                            r_out_rejected;

    t_counts                         cnt;
    t_state                          n_state;
    logic                            n_done;
    logic                            n_rejected;
    logic                            in_accept;
    logic                            fire;

    assign cnt.rst_low   = load_count(r_cfg[owm_pkg::CFG_RESET_LOW]);
    assign cnt.pres_wait = load_count(r_cfg[owm_pkg::CFG_PRESENCE_WAIT]);
    assign cnt.rst_rec   = load_count(r_cfg[owm_pkg::CFG_RESET_RECOVER]);
    assign cnt.short_low = load_count(r_cfg[owm_pkg::CFG_SHORT_LOW]);
    assign cnt.long_low  = load_count(r_cfg[owm_pkg::CFG_LONG_LOW]);
    assign cnt.rd_sample = load_count(r_cfg[owm_pkg::CFG_READ_SAMPLE]);
    assign cnt.rd_tail   = load_count(r_cfg[owm_pkg::CFG_READ_TAIL]);

    assign fire        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || fire;
    assign in_accept   = i_cmd.valid && i_cmd.ready;

    always_comb begin
        t_state         s_dec;
        t_step          a0;
        t_step          a1;
        t_step          a2;
        t_step          a3;
        owm_pkg::t_byte mask;
        logic           wr_now;
        logic           rd_now;

        n_state    = r_state;
        n_done     = 1'b0;
        n_rejected = 1'b0;
        s_dec      = r_state;
        a0         = '{st: r_state, done: 1'b0};
        a1         = a0;
        a2         = a0;
        a3         = a0;
        mask       = '0;
        wr_now     = 1'b0;
        rd_now     = 1'b0;

        if (r_in_req != owm_pkg::REQ_TICK) begin
            if (r_state.phase != PH_IDLE) begin
                n_rejected = 1'b1;
            end else begin
                n_state.bit_index = '0;
                if (r_in_req == owm_pkg::REQ_RESET) begin
                    n_state.phase     = PH_RST_LOW;
                    n_state.time_left = cnt.rst_low;
                end else if (r_in_req == owm_pkg::REQ_WRITE) begin
                    n_state.tx_shift  = r_in_tx;
                    n_state.phase     = PH_WR_LOW;
                    n_state.time_left = r_in_tx[0] ? cnt.short_low : cnt.long_low;
                end else begin
                    n_state.rx_shift  = '0;
                    n_state.phase     = PH_RD_LOW;
                    n_state.time_left = cnt.short_low;
                end
            end
        end else if (r_state.phase != PH_IDLE) begin
            if (r_state.time_left != '0) begin
                s_dec.time_left = r_state.time_left - owm_pkg::t_count'(1);
            end
            a0 = '{st: s_dec, done: 1'b0};
            a1 = step(a0, r_in_level, cnt);
            a2 = step(a1, r_in_level, cnt);
            a3 = step(a2, r_in_level, cnt);
            wr_now = s_dec.time_left == '0 && cnt.short_low == '0 && cnt.long_low == '0
                     && (s_dec.phase == PH_WR_LOW || s_dec.phase == PH_WR_HIGH);
            rd_now = s_dec.time_left == '0 && cnt.short_low == '0
                     && cnt.rd_sample == '0 && cnt.rd_tail == '0
                     && (s_dec.phase == PH_RD_LOW || s_dec.phase == PH_RD_WAIT
                         || s_dec.phase == PH_RD_TAIL);
            mask = 8'hFF << s_dec.bit_index;
            if (s_dec.phase == PH_RD_TAIL) begin
                mask[s_dec.bit_index] = 1'b0;
            end
            if (wr_now || rd_now) begin
                n_state           = s_dec;
                n_state.phase     = PH_IDLE;
                n_state.time_left = '0;
                n_state.bit_index = '0;
                n_done            = 1'b1;
                if (wr_now) begin
                    n_state.tx_shift = '0;
                end else if (r_in_level) begin
                    n_state.rx_shift = s_dec.rx_shift | mask;
                end
            end else begin
                n_state = a3.st;
                n_done  = a3.done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[owm_pkg::CFG_RESET_LOW]     <= owm_pkg::INIT_RESET_LOW;
            r_cfg[owm_pkg::CFG_PRESENCE_WAIT] <= owm_pkg::INIT_PRESENCE_WAIT;
            r_cfg[owm_pkg::CFG_RESET_RECOVER] <= owm_pkg::INIT_RESET_RECOVER;
            r_cfg[owm_pkg::CFG_SHORT_LOW]     <= owm_pkg::INIT_SHORT_LOW;
            r_cfg[owm_pkg::CFG_LONG_LOW]      <= owm_pkg::INIT_LONG_LOW;
            r_cfg[owm_pkg::CFG_READ_SAMPLE]   <= owm_pkg::INIT_READ_SAMPLE;
            r_cfg[owm_pkg::CFG_READ_TAIL]     <= owm_pkg::INIT_READ_TAIL;
            r_state     <= '{phase: PH_IDLE, default: '0};
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx <= owm_pkg::CFG_READ_TAIL) begin
                r_cfg[i_cfg_idx] <= i_cfg_data;
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
                r_in_req   <= i_cmd.req_type;
                r_in_tx    <= i_cmd.tx_byte;
                r_in_level <= i_cmd.line_level;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_state        <= n_state;
                r_out_valid    <= 1'b1;
                r_out_drive    <= n_state.phase == PH_RST_LOW || n_state.phase == PH_WR_LOW
                                  || n_state.phase == PH_RD_LOW;
                r_out_busy     <= n_state.phase != PH_IDLE;
                r_out_done     <= n_done;
                r_out_presence <= n_state.presence;
                r_out_rx       <= n_state.rx_shift;
                r_out_rejected <= n_rejected;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.drive_low = r_out_drive;
    assign o_res.busy_res  = r_out_busy;
    assign o_res.done_res  = r_out_done;
    assign o_res.presence  = r_out_presence;
    assign o_res.rx_byte   = r_out_rx;
    assign o_res.rejected  = r_out_rejected;

endmodule

// File: hw/rtl/owm_checker.sv
// Port-level checks of the one-wire bus master and their bind.
module owm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_res_valid,
    input logic                            i_res_ready,
    input logic                            i_drive_low,
    input logic                            i_busy_res,
    input logic                            i_done_res,
    input logic                            i_presence,
    input logic [owm_pkg::BYTE_WIDTH-1:0]  i_rx_byte,
    input logic                            i_rejected
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result word valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_drive_low)
        && $stable(i_busy_res) && $stable(i_done_res) && $stable(i_presence)
        && $stable(i_rx_byte) && $stable(i_rejected))
        else $error("stalled result word changed");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_done_res |-> !i_busy_res && !i_drive_low && !i_rejected)
        else $error("done reported while still busy or rejected");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_rejected |-> i_busy_res)
        else $error("command rejected while idle");

    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_drive_low |-> i_busy_res)
        else $error("line driven low while idle");

endmodule

bind one_wire_master_controller owm_checker u_owm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_drive_low (o_res.drive_low),
    .i_busy_res  (o_res.busy_res),
    .i_done_res  (o_res.done_res),
    .i_presence  (o_res.presence),
    .i_rx_byte   (o_res.rx_byte),
    .i_rejected  (o_res.rejected)
);
